// ===== rtl/urb_pkg.sv =====
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and constants for the UART receive ring buffer.
// ----------------------------------------------------------------------------
package urb_pkg;

  // Ring geometry: DEPTH entries, at most DEPTH-1 bytes held
  localparam int unsigned DEPTH = 512;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // Result field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned WORD_W  = 12;
  localparam int unsigned LEVEL_W = 9;
  localparam int unsigned CNT_W   = 32;

  // Flag pattern that still lets a byte into the ring
  localparam logic [FLAG_W-1:0] FLAG_OVERRUN_ONLY = 4'h8;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request codes on the input channel
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_FLUSH,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic                keep;    // push byte goes to the ring
    logic                err;     // push word carries an error flag
    logic [FLAG_W-1:0]   flags;
    logic [BYTE_W-1:0]   data;
  } urb_op_t;

  // Back end sequencer
  typedef enum logic {
    ST_ISSUE,
    ST_REPORT
  } back_state_t;

endpackage

// ===== rtl/urb_if.sv =====
// ----------------------------------------------------------------------------
// urb_if
// Request and response channels of the UART receive ring buffer.
// ----------------------------------------------------------------------------
interface urb_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      mode;
  logic [urb_pkg::WORD_W-1:0]      uart_word;

  modport source (output valid, output mode, output uart_word, input ready);
  modport sink   (input valid, input mode, input uart_word, output ready);
endinterface

interface urb_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [urb_pkg::BYTE_W-1:0]      byte_out;
  logic                            got_byte;
  logic                            stored;
  logic [urb_pkg::LEVEL_W-1:0]     fill_level;
  logic [urb_pkg::LEVEL_W-1:0]     peak_level;
  logic [urb_pkg::CNT_W-1:0]       dropped_total;
  logic [urb_pkg::CNT_W-1:0]       error_total;
  logic [urb_pkg::FLAG_W-1:0]      last_error_flags;
  logic [urb_pkg::BYTE_W-1:0]      last_seen_byte;
  logic [urb_pkg::CNT_W-1:0]       delivered_total;

  modport source (
    output valid, output byte_out, output got_byte, output stored,
    output fill_level, output peak_level, output dropped_total,
    output error_total, output last_error_flags, output last_seen_byte,
    output delivered_total, input ready
  );
  modport sink (
    input valid, input byte_out, input got_byte, input stored,
    input fill_level, input peak_level, input dropped_total,
    input error_total, input last_error_flags, input last_seen_byte,
    input delivered_total, output ready
  );
endinterface

// ===== rtl/urb_front.sv =====
// ----------------------------------------------------------------------------
// urb_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module urb_front (
  input  logic               clk,
  input  logic               rst,
  urb_req_if.sink            req,
  output urb_pkg::urb_op_t   op,
  output logic               op_valid,
  input  logic               op_ready
);

  urb_pkg::urb_op_t                q_mem [urb_pkg::QUEUE_DEPTH];
  logic [urb_pkg::QPTR_W-1:0]      wr_ptr;
  logic [urb_pkg::QPTR_W-1:0]      rd_ptr;
  logic [urb_pkg::QCNT_W-1:0]      count;
  logic [urb_pkg::QCNT_W-1:0]      count_next;
  urb_pkg::urb_op_t                cls;
  logic [urb_pkg::FLAG_W-1:0]      flags;
  logic                            push;
  logic                            pop;

  // Classify the incoming request
  always_comb begin
    flags     = req.uart_word[urb_pkg::WORD_W-1:urb_pkg::BYTE_W];
    cls.data  = req.uart_word[urb_pkg::BYTE_W-1:0];
    cls.flags = flags;
    cls.err   = 1'b0;
    cls.keep  = 1'b0;
    unique case (urb_pkg::mode_t'(req.mode))
      urb_pkg::MODE_PUSH: begin
        cls.kind = urb_pkg::OP_PUSH;
        cls.err  = (flags != '0);
        cls.keep = (flags == '0) || (flags == urb_pkg::FLAG_OVERRUN_ONLY);
      end
      urb_pkg::MODE_POP:   cls.kind = urb_pkg::OP_POP;
      urb_pkg::MODE_FLUSH: cls.kind = urb_pkg::OP_FLUSH;
      urb_pkg::MODE_NONE:  cls.kind = urb_pkg::OP_NOP;
    endcase
  end

  // Queue handshakes
  assign req.ready = (count != urb_pkg::QCNT_W'(urb_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign op_valid  = (count != '0);
  assign pop       = op_valid && op_ready;
  assign op        = q_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == urb_pkg::QPTR_W'(urb_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == urb_pkg::QPTR_W'(urb_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/urb_back.sv =====
// ----------------------------------------------------------------------------
// urb_back
// Executes queued operations on the ring, counters and result register.
// ----------------------------------------------------------------------------
module urb_back (
  input  logic               clk,
  input  logic               rst,
  input  urb_pkg::urb_op_t   op,
  input  logic               op_valid,
  output logic               op_ready,
  urb_rsp_if.source          rsp
);

  // Ring memory and read data
  logic [urb_pkg::BYTE_W-1:0]  ring [urb_pkg::DEPTH];
  logic [urb_pkg::BYTE_W-1:0]  ram_q;

  // Architectural state
  logic [urb_pkg::IDX_W-1:0]   wr_idx;
  logic [urb_pkg::IDX_W-1:0]   rd_idx;
  logic [urb_pkg::IDX_W-1:0]   peak;
  logic [urb_pkg::CNT_W-1:0]   drop_cnt;
  logic [urb_pkg::CNT_W-1:0]   err_cnt;
  logic [urb_pkg::FLAG_W-1:0]  err_flags;
  logic [urb_pkg::BYTE_W-1:0]  recent;
  logic [urb_pkg::CNT_W-1:0]   deliv_cnt;
  logic                        got_r;
  logic                        stored_r;

  // Sequencer
  urb_pkg::back_state_t        state;
  urb_pkg::back_state_t        state_next;
  logic                        take;
  logic                        report;
  logic                        ram_we;
  logic                        ram_re;

  // Result register
  logic                        out_valid;
  logic [urb_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_got;
  logic                        out_stored;
  logic [urb_pkg::LEVEL_W-1:0] out_fill;
  logic [urb_pkg::LEVEL_W-1:0] out_peak;
  logic [urb_pkg::CNT_W-1:0]   out_drop;
  logic [urb_pkg::CNT_W-1:0]   out_err;
  logic [urb_pkg::FLAG_W-1:0]  out_flags;
  logic [urb_pkg::BYTE_W-1:0]  out_seen;
  logic [urb_pkg::CNT_W-1:0]   out_deliv;

  // Index arithmetic
  logic [urb_pkg::IDX_W-1:0]   wr_nxt;
  logic [urb_pkg::IDX_W-1:0]   rd_nxt;
  logic [urb_pkg::IDX_W:0]     diff;
  logic [urb_pkg::IDX_W-1:0]   fill;
  logic [urb_pkg::IDX_W-1:0]   fill_inc;
  logic                        ring_full;
  logic                        ring_empty;

  always_comb begin
    wr_nxt = (wr_idx == urb_pkg::IDX_W'(urb_pkg::DEPTH - 1)) ? '0 : wr_idx + 1'b1;
    rd_nxt = (rd_idx == urb_pkg::IDX_W'(urb_pkg::DEPTH - 1)) ? '0 : rd_idx + 1'b1;
    diff   = (urb_pkg::IDX_W+1)'(wr_idx) + (urb_pkg::IDX_W+1)'(urb_pkg::DEPTH)
             - (urb_pkg::IDX_W+1)'(rd_idx);
    if (diff >= (urb_pkg::IDX_W+1)'(urb_pkg::DEPTH)) begin
      fill = urb_pkg::IDX_W'(diff - (urb_pkg::IDX_W+1)'(urb_pkg::DEPTH));
    end else begin
      fill = urb_pkg::IDX_W'(diff);
    end
    fill_inc   = fill + 1'b1;
    ring_full  = (wr_nxt == rd_idx);
    ring_empty = (rd_idx == wr_idx);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      urb_pkg::ST_ISSUE:  if (take) state_next = urb_pkg::ST_REPORT;
      urb_pkg::ST_REPORT: state_next = urb_pkg::ST_ISSUE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    op_ready = 1'b0;
    report   = 1'b0;
    unique case (state)
      urb_pkg::ST_ISSUE:  op_ready = !out_valid || rsp.ready;
      urb_pkg::ST_REPORT: report   = 1'b1;
    endcase
    take   = op_valid && op_ready;
    ram_we = take && (op.kind == urb_pkg::OP_PUSH) && op.keep && !ring_full;
    ram_re = take && (op.kind == urb_pkg::OP_POP) && !ring_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urb_pkg::ST_ISSUE;
    end else begin
      state <= state_next;
    end
  end

  // Ring memory, synchronous write and registered read
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ring[wr_idx] <= op.data;
    end
    if (ram_re) begin
      ram_q <= ring[rd_idx];
    end
  end

  // Operation execution
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx    <= '0;
      rd_idx    <= '0;
      peak      <= '0;
      drop_cnt  <= '0;
      err_cnt   <= '0;
      err_flags <= '0;
      recent    <= '0;
      deliv_cnt <= '0;
      got_r     <= 1'b0;
      stored_r  <= 1'b0;
    end else if (take) begin
      got_r    <= 1'b0;
      stored_r <= 1'b0;
      unique case (op.kind)
        urb_pkg::OP_PUSH: begin
          if (op.err) begin
            err_cnt   <= err_cnt + 1'b1;
            err_flags <= op.flags;
          end
          recent <= op.data;
          if (op.keep) begin
            if (ring_full) begin
              drop_cnt <= drop_cnt + 1'b1;
            end else begin
              wr_idx   <= wr_nxt;
              stored_r <= 1'b1;
              if (fill_inc > peak) begin
                peak <= fill_inc;
              end
            end
          end
        end
        urb_pkg::OP_POP: begin
          if (!ring_empty) begin
            rd_idx    <= rd_nxt;
            deliv_cnt <= deliv_cnt + 1'b1;
            got_r     <= 1'b1;
          end
        end
        urb_pkg::OP_FLUSH: begin
          wr_idx <= '0;
          rd_idx <= '0;
          peak   <= '0;
        end
        urb_pkg::OP_NOP: ;
      endcase
    end else if (report && got_r) begin
      // popped byte becomes the most recent one
      recent <= ram_q;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, taken from state after the operation
  always_ff @(posedge clk) begin
    if (report) begin
      out_byte   <= got_r ? ram_q : '0;
      out_got    <= got_r;
      out_stored <= stored_r;
      out_fill   <= urb_pkg::LEVEL_W'(fill);
      out_peak   <= urb_pkg::LEVEL_W'(peak);
      out_drop   <= drop_cnt;
      out_err    <= err_cnt;
      out_flags  <= err_flags;
      out_seen   <= got_r ? ram_q : recent;
      out_deliv  <= deliv_cnt;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.byte_out         = out_byte;
  assign rsp.got_byte         = out_got;
  assign rsp.stored           = out_stored;
  assign rsp.fill_level       = out_fill;
  assign rsp.peak_level       = out_peak;
  assign rsp.dropped_total    = out_drop;
  assign rsp.error_total      = out_err;
  assign rsp.last_error_flags = out_flags;
  assign rsp.last_seen_byte   = out_seen;
  assign rsp.delivered_total  = out_deliv;

endmodule

// ===== rtl/uart_rx_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// uart_rx_ring_buffer_unit
// UART receive ring buffer: request queue front end, ring and counter back end.
// ----------------------------------------------------------------------------
// A request passes the front queue, the back end's issue state and its report
// state into the result register; the issue/report sequence around the ring's
// registered read port takes no new operation while one is being reported.
// Reset: rst (synchronous) empties the ring and queue and zeroes all counters;
// ring contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module uart_rx_ring_buffer_unit (
  input  logic      clk,
  input  logic      rst,
  urb_req_if.sink   req,
  urb_rsp_if.source rsp
);

  urb_pkg::urb_op_t op;
  logic             op_valid;
  logic             op_ready;

  urb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready)
  );

  urb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .rsp      (rsp)
  );

  // A flush shows an empty ring and cleared high-water mark in its result
  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready && (op.kind == urb_pkg::OP_FLUSH) |=> ##1
      (rsp.valid && (rsp.fill_level == '0) && (rsp.peak_level == '0)))
    else $error("flush result does not show an empty ring");

  // Stored byte: ring not empty and high-water mark covers the fill level
  a_stored_peak: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.stored |->
      (rsp.fill_level != '0) && (rsp.peak_level >= rsp.fill_level))
    else $error("stored byte with inconsistent fill or peak level");

  // No byte returned means a zero byte field
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.got_byte |-> (rsp.byte_out == '0))
    else $error("byte_out set without got_byte");

endmodule

// ===== test/urb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urb_checker
// Watches the request and response channels of the UART receive ring buffer.
// Keeps its own copy of the ring, indices and counters, works out the status
// that each accepted request should produce, and compares every response
// transfer against the oldest outstanding status, field by field.
// ----------------------------------------------------------------------------
module urb_checker (
  input  logic        clk,
  input  logic        rst,
  urb_req_if          req,
  urb_rsp_if          rsp,
  output int unsigned fail_count,
  output int unsigned awaiting
);
  import urb_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_out;
    logic               got_byte;
    logic               stored;
    logic [LEVEL_W-1:0] fill_level;
    logic [LEVEL_W-1:0] peak_level;
    logic [CNT_W-1:0]   dropped_total;
    logic [CNT_W-1:0]   error_total;
    logic [FLAG_W-1:0]  last_error_flags;
    logic [BYTE_W-1:0]  last_seen_byte;
    logic [CNT_W-1:0]   delivered_total;
  } rx_status_t;

  // Shadow of the block's ring and bookkeeping
  logic [BYTE_W-1:0]  ring_mem [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] peak;
  logic [CNT_W-1:0]   drops;
  logic [CNT_W-1:0]   errs;
  logic [CNT_W-1:0]   delivered;
  logic [FLAG_W-1:0]  flags_seen;
  logic [BYTE_W-1:0]  recent;
  rx_status_t         status_due [$];
  rx_status_t         head;

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [LEVEL_W-1:0] bytes_held();
    return LEVEL_W'((32'(wr_ptr) + DEPTH - 32'(rd_ptr)) % DEPTH);
  endfunction

  // Apply one request to the shadow state and return the status it reports
  function automatic rx_status_t next_status(input logic [1:0] m,
                                             input logic [WORD_W-1:0] w);
    rx_status_t        s;
    logic [FLAG_W-1:0] fl;
    logic              keep;
    s    = '0;
    fl   = w[WORD_W-1:BYTE_W];
    keep = 1'b1;
    case (mode_t'(m))
      MODE_PUSH: begin
        if (fl != '0) begin
          errs       = errs + 1'b1;
          flags_seen = fl;
          keep       = (fl == FLAG_OVERRUN_ONLY);
        end
        recent = w[BYTE_W-1:0];
        if (keep) begin
          // full ring: one slot always left empty
          if (ring_next(wr_ptr) == rd_ptr) begin
            drops = drops + 1'b1;
          end else begin
            ring_mem[wr_ptr] = w[BYTE_W-1:0];
            wr_ptr           = ring_next(wr_ptr);
            s.stored         = 1'b1;
            if (bytes_held() > peak) peak = bytes_held();
          end
        end
      end
      MODE_POP: begin
        if (rd_ptr != wr_ptr) begin
          s.byte_out = ring_mem[rd_ptr];
          s.got_byte = 1'b1;
          rd_ptr     = ring_next(rd_ptr);
          delivered  = delivered + 1'b1;
          recent     = s.byte_out;
        end
      end
      MODE_FLUSH: begin
        // counters and recorded byte/flags survive a flush
        wr_ptr = '0;
        rd_ptr = '0;
        peak   = '0;
      end
      default: ;
    endcase
    s.fill_level       = bytes_held();
    s.peak_level       = peak;
    s.dropped_total    = drops;
    s.error_total      = errs;
    s.last_error_flags = flags_seen;
    s.last_seen_byte   = recent;
    s.delivered_total  = delivered;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
    end
  endtask

  // Response compared first: a request taken at this edge cannot answer yet
  always @(posedge clk) begin
    if (rst) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      peak       = '0;
      drops      = '0;
      errs       = '0;
      delivered  = '0;
      flags_seen = '0;
      recent     = '0;
      status_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (status_due.size() == 0) begin
          fail_count++;
          $display("%0t: response transfer with nothing outstanding, expected none, "
                   , $time, "actual fill 0x%0h", rsp.fill_level);
        end else begin
          head = status_due.pop_front();
          check_field("byte_out",         head.byte_out,         rsp.byte_out);
          check_field("got_byte",         head.got_byte,         rsp.got_byte);
          check_field("stored",           head.stored,           rsp.stored);
          check_field("fill_level",       head.fill_level,       rsp.fill_level);
          check_field("peak_level",       head.peak_level,       rsp.peak_level);
          check_field("dropped_total",    head.dropped_total,    rsp.dropped_total);
          check_field("error_total",      head.error_total,      rsp.error_total);
          check_field("last_error_flags", head.last_error_flags, rsp.last_error_flags);
          check_field("last_seen_byte",   head.last_seen_byte,   rsp.last_seen_byte);
          check_field("delivered_total",  head.delivered_total,  rsp.delivered_total);
        end
      end
      if (req.valid && req.ready)
        status_due.push_back(next_status(req.mode, req.uart_word));
    end
    awaiting = status_due.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UART receive ring buffer. A directed opening
// covers flag combinations, every request code, empty pops and flushes; the
// random part runs mixed traffic under several idling regimes, fills the ring
// past full behind a long response hold-off, churns it at the wrap and
// flushes it from full. Checking is done by urb_checker.
// ----------------------------------------------------------------------------
module tb;
  import urb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned PHASE_ITEMS    = 12;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count;
  int unsigned awaiting;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;
  bit          hold_req      = 1'b0;

  urb_req_if req ();
  urb_rsp_if rsp ();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  uart_rx_ring_buffer_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  urb_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: random stalls, or a long hold-off on request
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Received word: mostly clean or overrun-only, some with random flags
  function automatic logic [WORD_W-1:0] rx_word(input int unsigned err_pct);
    logic [FLAG_W-1:0] fl;
    if ($urandom_range(99) < err_pct)
      fl = FLAG_W'($urandom_range(15));
    else
      fl = $urandom_range(1) ? FLAG_OVERRUN_ONLY : '0;
    return {fl, BYTE_W'($urandom_range(255))};
  endfunction

  // Remainder above push+pop goes to flush, the top three percent unused
  function automatic mode_t pick_mode(input int unsigned push_pct,
                                      input int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct)           return MODE_PUSH;
    if (r < push_pct + pop_pct) return MODE_POP;
    if (r < 97)                 return MODE_FLUSH;
    return MODE_NONE;
  endfunction

  // One request transfer, with random idle cycles ahead of it
  task automatic send(input mode_t m, input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.mode      <= m;
    req.uart_word <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Sender pauses until every outstanding response has come back
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic mixed_run(input int unsigned count, input int unsigned push_pct,
                           input int unsigned pop_pct, input int unsigned err_pct);
    repeat (count) send(pick_mode(push_pct, pop_pct), rx_word(err_pct));
  endtask

  initial begin : stimulus
    int unsigned       kept;
    logic [WORD_W-1:0] w;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.mode      <= MODE_PUSH;
    req.uart_word <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening
    send(MODE_POP,   12'hFFF);   // pop on empty ring
    send(MODE_PUSH,  12'h000);
    send(MODE_PUSH,  12'h0FF);
    send(MODE_PUSH,  12'h8A5);   // overrun alone: still kept
    send(MODE_PUSH,  12'h13C);   // framing: rejected
    send(MODE_PUSH,  12'h2C3);   // parity
    send(MODE_PUSH,  12'h45A);   // break
    send(MODE_PUSH,  12'h911);   // overrun with framing: rejected
    send(MODE_PUSH,  12'hFFF);   // every flag
    send(MODE_NONE,  12'hFFF);   // unused code, status only
    repeat (4) send(MODE_POP, 12'h000);   // three bytes, then empty
    send(MODE_PUSH,  12'h066);
    send(MODE_PUSH,  12'h877);
    send(MODE_FLUSH, 12'h000);   // flush with bytes held
    send(MODE_POP,   12'h000);   // empty after flush
    send(MODE_PUSH,  12'h0AB);
    send(MODE_FLUSH, 12'hFFF);
    settle();

    // Mixed traffic under each idling regime
    send_idle_pct = 0;  stall_pct = 0;
    mixed_run(PHASE_ITEMS, 55, 38, 30);
    send_idle_pct = 88; stall_pct = 0;
    mixed_run(PHASE_ITEMS, 55, 38, 30);
    settle();
    send_idle_pct = 0;  stall_pct = 88;
    mixed_run(PHASE_ITEMS, 55, 38, 30);
    send_idle_pct = 30; stall_pct = 30;
    mixed_run(PHASE_ITEMS, 55, 38, 30);
    settle();

    // Fill past full while responses are held off, so the input backs up
    send_idle_pct = 0; stall_pct = 0;
    hold_req = 1'b1;
    kept = 0;
    while (kept < DEPTH + 8) begin
      w = rx_word(0);
      if (w[WORD_W-1:BYTE_W] == '0 || w[WORD_W-1:BYTE_W] == FLAG_OVERRUN_ONLY)
        kept++;
      send(MODE_PUSH, w);
    end
    settle();

    // Churn near full so the write index wraps, then flush from there
    send_idle_pct = 30; stall_pct = 30;
    mixed_run(PHASE_ITEMS, 50, 47, 10);
    send(MODE_FLUSH, rx_word(100));
    mixed_run(PHASE_ITEMS, 55, 38, 30);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
